/* hdl/text_glyph_renderer_assert.svh */
// ----------------------------------------------------------------------------
// text_glyph_renderer_assert
// Assertion macros for the text glyph renderer, included by tgr_ctrl. Each macro
// expects signals named clk and arst_n in the including scope.
// ----------------------------------------------------------------------------
`ifndef TEXT_GLYPH_RENDERER_ASSERT_SVH
`define TEXT_GLYPH_RENDERER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TGR_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TGR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/tgr_pkg.sv */
// ----------------------------------------------------------------------------
// tgr_pkg
// Types and constants shared by the text glyph renderer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tgr_pkg;

	localparam int CODE_W  = 8;
	localparam int LINE_W  = 4;
	localparam int COL_W   = 16;
	localparam int COLOR_W = 32;
	localparam int GW_W    = 4;
	localparam int GH_W    = 5;
	localparam int GS_W    = 4;
	localparam int TW_W    = 5;
	localparam int SCR_W   = 12;
	localparam int PITCH_W = 5;
	localparam int XY_W    = COL_W + PITCH_W;
	localparam int FIT_W   = XY_W + 1;
	localparam int ADDR_W  = 24;
	localparam int IDX_W   = CODE_W + GH_W + 1;
	localparam int NPIX    = 8;

	typedef logic [2:0]       cfg_idx_t;
	typedef logic [SCR_W-1:0] cfg_data_t;

	localparam cfg_idx_t REG_GLYPH_WIDTH   = 3'd0;
	localparam cfg_idx_t REG_GLYPH_HEIGHT  = 3'd1;
	localparam cfg_idx_t REG_GLYPH_SPACING = 3'd2;
	localparam cfg_idx_t REG_TAB_WIDTH     = 3'd3;
	localparam cfg_idx_t REG_SCREEN_WIDTH  = 3'd4;
	localparam cfg_idx_t REG_SCREEN_HEIGHT = 3'd5;

	localparam logic [GW_W-1:0]  RST_GLYPH_WIDTH   = 4'd8;
	localparam logic [GH_W-1:0]  RST_GLYPH_HEIGHT  = 5'd16;
	localparam logic [GS_W-1:0]  RST_GLYPH_SPACING = 4'd1;
	localparam logic [TW_W-1:0]  RST_TAB_WIDTH     = 5'd4;
	localparam logic [SCR_W-1:0] RST_SCREEN_WIDTH  = 12'd640;
	localparam logic [SCR_W-1:0] RST_SCREEN_HEIGHT = 12'd480;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TEXT = 1'b1;

	localparam logic [CODE_W-1:0] TAB_CODE = 8'h09;
	localparam logic [CODE_W-1:0] PRINT_LO = 8'h20;
	localparam logic [CODE_W-1:0] PRINT_HI = 8'h7E;

	typedef struct packed {
		logic                 operation;
		logic [CODE_W-1:0]    char_code;
		logic [LINE_W-1:0]    glyph_line;
		logic [NPIX-1:0]      glyph_bits;
		logic                 start_run;
		logic [COL_W-1:0]     start_col;
		logic [COL_W-1:0]     cell_row;
		logic [COLOR_W-1:0]   ink_color;
		logic [COLOR_W-1:0]   paper_color;
	} item_t;

	typedef struct packed {
		logic [ADDR_W-1:0]              pixel_address;
		logic [NPIX-1:0][COLOR_W-1:0]   pixels;
		logic                           last_line;
	} res_t;

	typedef struct packed {
		logic capture;
		logic write;
		logic calc;
		logic check;
		logic base;
		logic issue;
		logic advance;
	} cmd_t;

	typedef struct packed {
		logic is_load;
		logic draw;
		logic last_row;
	} sts_t;

endpackage

`default_nettype wire

/* hdl/tgr_item_if.sv */
// ----------------------------------------------------------------------------
// tgr_item_if
// Input channel: glyph row loads and text characters.
// ----------------------------------------------------------------------------
`default_nettype none

interface tgr_item_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [7:0]  char_code;
	logic [3:0]  glyph_line;
	logic [7:0]  glyph_bits;
	logic        start_run;
	logic [15:0] start_col;
	logic [15:0] cell_row;
	logic [31:0] ink_color;
	logic [31:0] paper_color;

	modport source (
		output valid, operation, char_code, glyph_line, glyph_bits, start_run,
		       start_col, cell_row, ink_color, paper_color,
		input  ready
	);
	modport sink (
		input  valid, operation, char_code, glyph_line, glyph_bits, start_run,
		       start_col, cell_row, ink_color, paper_color,
		output ready
	);
endinterface

`default_nettype wire

/* hdl/tgr_result_if.sv */
// ----------------------------------------------------------------------------
// tgr_result_if
// Output channel: one glyph row of eight pixels and its framebuffer address.
// ----------------------------------------------------------------------------
`default_nettype none

interface tgr_result_if;
	logic        valid;
	logic        ready;
	logic [23:0] pixel_address;
	logic [31:0] pixel_0;
	logic [31:0] pixel_1;
	logic [31:0] pixel_2;
	logic [31:0] pixel_3;
	logic [31:0] pixel_4;
	logic [31:0] pixel_5;
	logic [31:0] pixel_6;
	logic [31:0] pixel_7;
	logic        last_line;

	modport source (
		output valid, pixel_address, pixel_0, pixel_1, pixel_2, pixel_3, pixel_4,
		       pixel_5, pixel_6, pixel_7, last_line,
		input  ready
	);
	modport sink (
		input  valid, pixel_address, pixel_0, pixel_1, pixel_2, pixel_3, pixel_4,
		       pixel_5, pixel_6, pixel_7, last_line,
		output ready
	);
endinterface

`default_nettype wire

/* hdl/text_glyph_renderer.sv */
// A load item is accepted and then its glyph row is written into the
// single-port font memory. A text item runs through its setup steps
// (accept, column update with the cell multiplies, bounds check with the row
// address multiply, base address) and then reads one glyph row per cycle from
// the font memory while the output is not stalled, for glyph_height rows capped
// at MAX_GLYPH_ROWS. The last row read moves into the output register before
// the next item is taken. A tab, a control code or a cell off the screen ends
// after the bounds check and draws no rows. Rows leave through an output
// register, so the next item is taken while the last row still waits on the
// output. The font memory is not cleared at reset; rows must be loaded before
// they are drawn.
// ----------------------------------------------------------------------------
// text_glyph_renderer
// Character generator: renders text cells from a loadable bitmap font into
// framebuffer rows of eight pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module text_glyph_renderer #(
	parameter int FONT_CODES     = 128,
	parameter int MAX_GLYPH_ROWS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  tgr_pkg::cfg_idx_t   cfg_index,
	input  tgr_pkg::cfg_data_t  cfg_data,
	tgr_item_if.sink            item,
	tgr_result_if.source        result
);
	import tgr_pkg::*;

	item_t item_data;
	cmd_t  cmd;
	sts_t  sts;
	res_t  res;

	assign item_data.operation   = item.operation;
	assign item_data.char_code   = item.char_code;
	assign item_data.glyph_line  = item.glyph_line;
	assign item_data.glyph_bits  = item.glyph_bits;
	assign item_data.start_run   = item.start_run;
	assign item_data.start_col   = item.start_col;
	assign item_data.cell_row    = item.cell_row;
	assign item_data.ink_color   = item.ink_color;
	assign item_data.paper_color = item.paper_color;

	tgr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	tgr_dp #(
		.FONT_CODES     (FONT_CODES),
		.MAX_GLYPH_ROWS (MAX_GLYPH_ROWS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_data),
		.cmd       (cmd),
		.sts       (sts),
		.res       (res)
	);

	assign result.pixel_address = res.pixel_address;
	assign result.pixel_0       = res.pixels[0];
	assign result.pixel_1       = res.pixels[1];
	assign result.pixel_2       = res.pixels[2];
	assign result.pixel_3       = res.pixels[3];
	assign result.pixel_4       = res.pixels[4];
	assign result.pixel_5       = res.pixels[5];
	assign result.pixel_6       = res.pixels[6];
	assign result.pixel_7       = res.pixels[7];
	assign result.last_line     = res.last_line;

endmodule

`default_nettype wire

/* hdl/tgr_ctrl.sv */
// ----------------------------------------------------------------------------
// tgr_ctrl
// Sequencer for the renderer: steps an item through its phases and runs the
// two-stage row pipeline (font read, output register).
// ----------------------------------------------------------------------------
`default_nettype none

module tgr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output tgr_pkg::cmd_t cmd,
	input  tgr_pkg::sts_t sts
);
	import tgr_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CALC  = 3'd1;
	localparam logic [2:0] S_CHECK = 3'd2;
	localparam logic [2:0] S_BASE  = 3'd3;
	localparam logic [2:0] S_ROWS  = 3'd4;

	logic [2:0] state_q, state_d;
	logic       s1_valid_q;
	logic       out_valid_q;
	logic       accept, adv, issue;

	// A new item waits until the last font read has moved to the output register,
	// since that move still uses the current item's colors.
	assign in_ready  = (state_q == S_IDLE) && !s1_valid_q;
	assign accept    = in_valid && in_ready;
	assign adv       = s1_valid_q && (!out_valid_q || out_ready);
	assign issue     = (state_q == S_ROWS) && (!s1_valid_q || adv);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd         = '0;
		cmd.capture = accept;
		cmd.write   = (state_q == S_CALC) && sts.is_load;
		cmd.calc    = (state_q == S_CALC) && !sts.is_load;
		cmd.check   = (state_q == S_CHECK);
		cmd.base    = (state_q == S_BASE);
		cmd.issue   = issue;
		cmd.advance = adv;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_CALC;
			end
			S_CALC: begin
				state_d = sts.is_load ? S_IDLE : S_CHECK;
			end
			S_CHECK: begin
				state_d = sts.draw ? S_BASE : S_IDLE;
			end
			S_BASE: begin
				state_d = S_ROWS;
			end
			S_ROWS: begin
				if (issue && sts.last_row) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (issue) s1_valid_q <= 1'b1;
			else if (adv) s1_valid_q <= 1'b0;
			if (adv) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	`include "text_glyph_renderer_assert.svh"

	`TGR_ASSERT_NEXT(a_last_row_ends, issue && sts.last_row, (state_q == S_IDLE) && s1_valid_q, "last row issue did not end the character")
	`TGR_ASSERT_NEXT(a_row_held, s1_valid_q && out_valid_q && !out_ready, s1_valid_q && out_valid_q, "stalled glyph row was dropped")
	`TGR_ASSERT_SAME(a_pipe_empty, (state_q == S_CALC) || (state_q == S_CHECK) || (state_q == S_BASE), !s1_valid_q, "row pipeline busy while a new item is set up")

endmodule

`default_nettype wire

/* hdl/tgr_dp.sv */
// ----------------------------------------------------------------------------
// tgr_dp
// Datapath: configuration registers, font memory, column tracking, cell
// geometry and the glyph row pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module tgr_dp #(
	parameter int FONT_CODES     = 128,
	parameter int MAX_GLYPH_ROWS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  tgr_pkg::cfg_idx_t   cfg_index,
	input  tgr_pkg::cfg_data_t  cfg_data,
	input  tgr_pkg::item_t      item,
	input  tgr_pkg::cmd_t       cmd,
	output tgr_pkg::sts_t       sts,
	output tgr_pkg::res_t       res
);
	import tgr_pkg::*;

	localparam int DEPTH = FONT_CODES * MAX_GLYPH_ROWS;
	localparam int FA_W  = $clog2(DEPTH);
	localparam int RW    = $clog2(MAX_GLYPH_ROWS + 1);

	logic [GW_W-1:0]  gw_q;
	logic [GH_W-1:0]  gh_q;
	logic [GS_W-1:0]  gs_q;
	logic [TW_W-1:0]  tw_q;
	logic [SCR_W-1:0] sw_q;
	logic [SCR_W-1:0] sh_q;

	item_t             item_q;
	logic [COL_W-1:0]  ncol_q;
	logic [XY_W-1:0]   x_q, y_q;
	logic [IDX_W-1:0]  gbase_q;
	logic [ADDR_W-1:0] prod_q, addr_q;
	logic [RW-1:0]     rows_q, row_q;

	logic [NPIX-1:0]   mem [DEPTH];
	logic [NPIX-1:0]   rd_s1;
	logic              zero_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              last_s1;
	res_t              res_q;

	logic [IDX_W-1:0]   gbase, load_idx, rd_idx;
	logic [COL_W-1:0]   col;
	logic [PITCH_W-1:0] pitch;
	logic               is_tab, printable, fits;
	logic [NPIX-1:0]    row_bits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gw_q <= RST_GLYPH_WIDTH;
			gh_q <= RST_GLYPH_HEIGHT;
			gs_q <= RST_GLYPH_SPACING;
			tw_q <= RST_TAB_WIDTH;
			sw_q <= RST_SCREEN_WIDTH;
			sh_q <= RST_SCREEN_HEIGHT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GLYPH_WIDTH:   gw_q <= cfg_data[GW_W-1:0];
				REG_GLYPH_HEIGHT:  gh_q <= cfg_data[GH_W-1:0];
				REG_GLYPH_SPACING: gs_q <= cfg_data[GS_W-1:0];
				REG_TAB_WIDTH:     tw_q <= cfg_data[TW_W-1:0];
				REG_SCREEN_WIDTH:  sw_q <= cfg_data;
				REG_SCREEN_HEIGHT: sh_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign gbase    = IDX_W'(item_q.char_code) * IDX_W'(gh_q);
	assign load_idx = gbase + IDX_W'(item_q.glyph_line);
	assign rd_idx   = gbase_q + IDX_W'(row_q);
	assign col      = item_q.start_run ? item_q.start_col : ncol_q;
	assign pitch    = PITCH_W'(gw_q) + PITCH_W'(gs_q);
	assign is_tab   = (item_q.char_code == TAB_CODE);
	assign printable = (item_q.char_code >= PRINT_LO) && (item_q.char_code <= PRINT_HI);
	// Bounds are checked as sums so that a cell larger than the screen never fits.
	assign fits = (FIT_W'(y_q) + FIT_W'(gh_q) <= FIT_W'(sh_q)) &&
	              (FIT_W'(x_q) + FIT_W'(pitch) <= FIT_W'(sw_q));

	assign sts.is_load  = (item_q.operation == OP_LOAD);
	assign sts.draw     = printable && (gh_q != '0) && fits;
	assign sts.last_row = ((row_q + RW'(1)) == rows_q);

	function automatic res_t res_next(input logic [NPIX-1:0] bits);
		res_t r;
		r.pixel_address = addr_s1;
		r.last_line     = last_s1;
		for (int j = 0; j < NPIX; j++) begin
			r.pixels[j] = bits[NPIX-1-j] ? item_q.ink_color : item_q.paper_color;
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.capture) item_q <= item;
		if (cmd.calc) begin
			x_q     <= XY_W'(col) * XY_W'(pitch);
			y_q     <= XY_W'(item_q.cell_row) * XY_W'(gh_q);
			gbase_q <= gbase;
		end
		if (cmd.check) begin
			prod_q <= ADDR_W'(y_q[SCR_W-1:0]) * ADDR_W'(sw_q);
			rows_q <= (32'(gh_q) > MAX_GLYPH_ROWS) ? RW'(MAX_GLYPH_ROWS) : RW'(gh_q);
		end
		if (cmd.base) begin
			addr_q <= prod_q + ADDR_W'(x_q);
			row_q  <= '0;
		end else if (cmd.issue) begin
			addr_q <= addr_q + ADDR_W'(sw_q);
			row_q  <= row_q + RW'(1);
		end
		if (cmd.issue) begin
			zero_s1 <= (rd_idx >= IDX_W'(DEPTH));
			addr_s1 <= addr_q;
			last_s1 <= sts.last_row;
		end
		if (cmd.advance) res_q <= res_next(row_bits);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ncol_q <= '0;
		end else if (cmd.calc) begin
			ncol_q <= is_tab ? col + COL_W'(tw_q) : col + COL_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write && (load_idx < IDX_W'(DEPTH))) begin
			mem[FA_W'(load_idx)] <= item_q.glyph_bits;
		end
		if (cmd.issue) rd_s1 <= mem[FA_W'(rd_idx)];
	end

	assign row_bits = zero_s1 ? '0 : rd_s1;

	assign res = res_q;

endmodule

`default_nettype wire
